>>> hdl/mrsm_pkg.sv
// ============================================================================
// mrsm_pkg
// Shared types and codes for the message ring space manager.
// ============================================================================
package mrsm_pkg;

    localparam int unsigned LEN_W  = 23;
    localparam int unsigned OFF_W  = 22;
    localparam int unsigned TS_W   = 64;
    localparam int unsigned VER_W  = 8;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned POS_W  = 32;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REWIND = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_LIMIT = 2'd2;
    localparam logic [STAT_W-1:0] ST_BIG   = 2'd3;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_W_CHECK,
        S_W_RELRD,
        S_W_RELWR,
        S_W_PLAN,
        S_W_FULLRD,
        S_W_FULLWR,
        S_W_APPEND,
        S_R_SAFE,
        S_R_RD,
        S_R_EVAL,
        S_RESULT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_BIG,
        OP_EMPTY,
        OP_ZERO,
        OP_DESC_OK,
        OP_DESC_LIMIT,
        OP_WRITE_OK
    } t_res_op;

    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    rel_rd;
        logic    rel_wr;
        logic    plan;
        logic    full_rd;
        logic    app_wr;
        logic    rewind;
        logic    safe;
        logic    rd_rd;
        logic    skip;
        logic    adv_reader;
        t_res_op res_op;
        logic    res_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_write;
        logic is_read;
        logic is_rewind;
        logic too_big;
        logic need_rel;
        logic fits;
        logic ring_full;
        logic last_round;
        logic at_tail;
        logic rd_pad;
        logic rd_over;
    } t_sts;

endpackage

>>> hdl/message_ring_space_manager_core.sv
// ============================================================================
// message_ring_space_manager_core
// Space manager for a variable-length message ring with one reader.
// ============================================================================
//  channel | signals                                   | dir
//  in      | i_in_valid/o_in_ready, kind length time   | in
//  out     | o_out_valid/i_out_ready, status ... dropped| out
//
//  One word at a time, up to its result. Rewind, unknown and refused words go
//  from decode straight to the result. A write releases the oldest messages
//  until the length fits, plans the append, frees the oldest descriptor
//  first when the ring is full, and checks again after each padding append.
//  A read bounds the reader lag, then reads descriptors, skipping padding
//  ones. After reset a clearing pass zeroes every descriptor before the first
//  word is taken. A stalled result holds the block until it is taken.
// ============================================================================
module message_ring_space_manager_core #(
    parameter int unsigned RING_DEPTH = 2048,
    parameter int unsigned BUF_BYTES  = 4194304
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [22:0] i_length,
    input  logic [63:0] i_timestamp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [21:0] o_offset,
    output logic [22:0] o_msg_length,
    output logic [63:0] o_msg_time,
    output logic [7:0]  o_version,
    output logic [31:0] o_dropped
);

    mrsm_pkg::t_cmd cmd;
    mrsm_pkg::t_sts sts;
    logic           r_out_valid;
    logic           res_free;

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    mrsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_res_free  (res_free),
        .i_res_taken (r_out_valid && i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mrsm_dp #(
        .RING_DEPTH (RING_DEPTH),
        .BUF_BYTES  (BUF_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_kind       (i_kind),
        .i_length     (i_length),
        .i_timestamp  (i_timestamp),
        .o_status     (o_status),
        .o_offset     (o_offset),
        .o_msg_length (o_msg_length),
        .o_msg_time   (o_msg_time),
        .o_version    (o_version),
        .o_dropped    (o_dropped)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_free |-> o_out_valid)
        else $error("result taken while empty");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken with result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |-> !o_out_valid)
        else $error("result overwritten");

endmodule

>>> hdl/mrsm_ctrl.sv
// ============================================================================
// mrsm_ctrl
// Sequencer for write, read and rewind words.
// ============================================================================
module mrsm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_res_free,
    input  logic             i_res_taken,
    input  mrsm_pkg::t_sts   i_sts,
    output mrsm_pkg::t_cmd   o_cmd
);

    mrsm_pkg::t_state r_state, n_state;
    logic             r_pad_app, n_pad_app;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mrsm_pkg::S_CLEAR;
            r_pad_app <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pad_app <= n_pad_app;
        end
    end

    assign o_res_free = i_res_taken;

    always_comb begin
        n_state   = r_state;
        n_pad_app = r_pad_app;
        unique case (r_state)
            mrsm_pkg::S_CLEAR:    if (i_sts.clr_done) n_state = mrsm_pkg::S_IDLE;
            mrsm_pkg::S_IDLE:     if (i_in_valid) n_state = mrsm_pkg::S_DECODE;
            mrsm_pkg::S_DECODE: begin
                if (i_sts.is_write) begin
                    n_state = i_sts.too_big ? mrsm_pkg::S_RESULT : mrsm_pkg::S_W_CHECK;
                end else if (i_sts.is_read) begin
                    n_state = mrsm_pkg::S_R_SAFE;
                end else begin
                    n_state = mrsm_pkg::S_RESULT;
                end
            end
            mrsm_pkg::S_W_CHECK:
                n_state = i_sts.need_rel ? mrsm_pkg::S_W_RELRD : mrsm_pkg::S_W_PLAN;
            mrsm_pkg::S_W_RELRD:  n_state = mrsm_pkg::S_W_RELWR;
            mrsm_pkg::S_W_RELWR:  n_state = mrsm_pkg::S_W_CHECK;
            mrsm_pkg::S_W_PLAN: begin
                if (!i_sts.fits && i_sts.last_round) begin
                    n_state = mrsm_pkg::S_RESULT;
                end else begin
                    n_pad_app = !i_sts.fits;
                    n_state   = i_sts.ring_full ? mrsm_pkg::S_W_FULLRD
                                                : mrsm_pkg::S_W_APPEND;
                end
            end
            mrsm_pkg::S_W_FULLRD: n_state = mrsm_pkg::S_W_FULLWR;
            mrsm_pkg::S_W_FULLWR: n_state = mrsm_pkg::S_W_APPEND;
            mrsm_pkg::S_W_APPEND:
                n_state = r_pad_app ? mrsm_pkg::S_W_CHECK : mrsm_pkg::S_RESULT;
            mrsm_pkg::S_R_SAFE:   n_state = mrsm_pkg::S_R_RD;
            mrsm_pkg::S_R_RD:     n_state = mrsm_pkg::S_R_EVAL;
            mrsm_pkg::S_R_EVAL: begin
                if (i_sts.at_tail || !i_sts.rd_pad) n_state = mrsm_pkg::S_RESULT;
                else                                n_state = mrsm_pkg::S_R_RD;
            end
            mrsm_pkg::S_RESULT:   if (i_res_taken) n_state = mrsm_pkg::S_IDLE;
            default:              n_state = mrsm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            mrsm_pkg::S_CLEAR: o_cmd.clr_step = 1'b1;
            mrsm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            mrsm_pkg::S_DECODE: begin
                if (i_sts.is_write) begin
                    if (i_sts.too_big) begin
                        o_cmd.res_op   = mrsm_pkg::OP_BIG;
                        o_cmd.res_load = 1'b1;
                    end
                end else if (!i_sts.is_read) begin
                    o_cmd.rewind   = i_sts.is_rewind;
                    o_cmd.res_op   = mrsm_pkg::OP_ZERO;
                    o_cmd.res_load = 1'b1;
                end
            end
            mrsm_pkg::S_W_RELRD:  o_cmd.rel_rd = 1'b1;
            mrsm_pkg::S_W_RELWR:  o_cmd.rel_wr = 1'b1;
            mrsm_pkg::S_W_PLAN: begin
                o_cmd.plan = 1'b1;
                if (!i_sts.fits && i_sts.last_round) begin
                    o_cmd.res_op   = mrsm_pkg::OP_BIG;
                    o_cmd.res_load = 1'b1;
                end
            end
            mrsm_pkg::S_W_FULLRD: o_cmd.rel_rd = 1'b1;
            mrsm_pkg::S_W_FULLWR: o_cmd.rel_wr = 1'b1;
            mrsm_pkg::S_W_APPEND: begin
                o_cmd.app_wr = 1'b1;
                if (!r_pad_app) begin
                    o_cmd.res_op   = mrsm_pkg::OP_WRITE_OK;
                    o_cmd.res_load = 1'b1;
                end
            end
            mrsm_pkg::S_R_SAFE:   o_cmd.safe = 1'b1;
            mrsm_pkg::S_R_RD:     o_cmd.rd_rd = 1'b1;
            mrsm_pkg::S_R_EVAL: begin
                if (i_sts.at_tail) begin
                    o_cmd.res_op   = mrsm_pkg::OP_EMPTY;
                    o_cmd.res_load = 1'b1;
                end else if (i_sts.rd_pad) begin
                    o_cmd.skip = 1'b1;
                end else if (i_sts.rd_over) begin
                    o_cmd.res_op   = mrsm_pkg::OP_DESC_LIMIT;
                    o_cmd.res_load = 1'b1;
                end else begin
                    o_cmd.adv_reader = 1'b1;
                    o_cmd.res_op     = mrsm_pkg::OP_DESC_OK;
                    o_cmd.res_load   = 1'b1;
                end
            end
            mrsm_pkg::S_RESULT: ;
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == mrsm_pkg::S_IDLE))
        else $error("ready outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.app_wr |-> $past(r_state == mrsm_pkg::S_W_PLAN
                               || r_state == mrsm_pkg::S_W_FULLWR))
        else $error("append without plan");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.res_load && r_state != mrsm_pkg::S_DECODE) |=>
            (r_state == mrsm_pkg::S_RESULT))
        else $error("result not held");

endmodule

>>> hdl/mrsm_dp.sv
// ============================================================================
// mrsm_dp
// Descriptor memory, ring pointers, byte pointers and result register.
// ============================================================================
module mrsm_dp #(
    parameter int unsigned RING_DEPTH = 2048,
    parameter int unsigned BUF_BYTES  = 4194304
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mrsm_pkg::t_cmd                i_cmd,
    output mrsm_pkg::t_sts                o_sts,
    input  logic [mrsm_pkg::KIND_W-1:0]   i_kind,
    input  logic [mrsm_pkg::LEN_W-1:0]    i_length,
    input  logic [mrsm_pkg::TS_W-1:0]     i_timestamp,
    output logic [mrsm_pkg::STAT_W-1:0]   o_status,
    output logic [mrsm_pkg::OFF_W-1:0]    o_offset,
    output logic [mrsm_pkg::LEN_W-1:0]    o_msg_length,
    output logic [mrsm_pkg::TS_W-1:0]     o_msg_time,
    output logic [mrsm_pkg::VER_W-1:0]    o_version,
    output logic [mrsm_pkg::CNT_W-1:0]    o_dropped
);

    localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
    localparam int unsigned BPOS_W = $clog2(BUF_BYTES) + 1;
    localparam int unsigned BIDX_W = BPOS_W - 1;
    localparam int unsigned DESC_W = mrsm_pkg::VER_W + 1 + mrsm_pkg::LEN_W
                                     + mrsm_pkg::TS_W + mrsm_pkg::OFF_W;
    localparam logic [mrsm_pkg::POS_W-1:0] ENTRIES = mrsm_pkg::POS_W'(RING_DEPTH);
    localparam logic [mrsm_pkg::POS_W-1:0] SAFE_SPAN =
        mrsm_pkg::POS_W'(RING_DEPTH - RING_DEPTH / 16);
    localparam logic [BPOS_W:0] BUF_SZ = (BPOS_W+1)'(BUF_BYTES);

    typedef struct packed {
        logic [mrsm_pkg::VER_W-1:0] ver;
        logic                       pad;
        logic [mrsm_pkg::LEN_W-1:0] len;
        logic [mrsm_pkg::TS_W-1:0]  ts;
        logic [mrsm_pkg::OFF_W-1:0] off;
    } t_desc;

    logic [DESC_W-1:0] r_mem [RING_DEPTH];
    t_desc             r_rdat;

    logic [IDX_W:0]                  r_clr;
    logic [mrsm_pkg::KIND_W-1:0]     r_kind;
    logic [mrsm_pkg::LEN_W-1:0]      r_len;
    logic [mrsm_pkg::TS_W-1:0]       r_ts;
    logic [mrsm_pkg::POS_W-1:0]      r_oldest, r_next, r_reader;
    logic [mrsm_pkg::CNT_W-1:0]      r_drop;
    logic [BPOS_W-1:0]               r_bhead, r_btail;
    logic [1:0]                      r_round;
    logic [mrsm_pkg::LEN_W-1:0]      r_app_len;
    logic                            r_app_pad;
    logic [mrsm_pkg::OFF_W-1:0]      r_app_off;

    logic [BPOS_W-1:0] used;
    logic [BPOS_W:0]   avail, trail, room;
    logic [BIDX_W-1:0] tail_idx;
    logic [mrsm_pkg::POS_W-1:0] gap;
    t_desc             wdesc;
    logic [IDX_W-1:0]  rd_addr;

    assign used     = r_btail - r_bhead;
    assign avail    = BUF_SZ - (BPOS_W+1)'(used);
    assign tail_idx = r_btail[BIDX_W-1:0];
    assign trail    = BUF_SZ - (BPOS_W+1)'(tail_idx);
    assign room     = (avail < trail) ? avail : trail;
    assign gap      = r_next - r_reader;

    assign o_sts.clr_done   = r_clr[IDX_W];
    assign o_sts.is_write   = (r_kind == mrsm_pkg::KIND_WRITE);
    assign o_sts.is_read    = (r_kind == mrsm_pkg::KIND_READ);
    assign o_sts.is_rewind  = (r_kind == mrsm_pkg::KIND_REWIND);
    assign o_sts.too_big    = ((BPOS_W+1)'(r_len) > BUF_SZ);
    assign o_sts.need_rel   = (avail < (BPOS_W+1)'(r_len)) && (r_oldest != r_next);
    assign o_sts.fits       = (room >= (BPOS_W+1)'(r_len));
    assign o_sts.ring_full  = ((r_next - r_oldest) >= ENTRIES);
    assign o_sts.last_round = (r_round == 2'd2);
    assign o_sts.at_tail    = (r_reader == r_next);
    assign o_sts.rd_pad     = r_rdat.pad;
    assign o_sts.rd_over    = (r_rdat.len > r_len);

    always_comb begin
        rd_addr = r_reader[IDX_W-1:0];
        if (i_cmd.rel_rd) rd_addr = r_oldest[IDX_W-1:0];
        if (i_cmd.plan)   rd_addr = r_next[IDX_W-1:0];
        wdesc     = r_rdat;
        wdesc.len = r_app_len;
        wdesc.ts  = r_app_pad ? '0 : r_ts;
        wdesc.pad = r_app_pad;
        wdesc.off = r_app_off;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr[IDX_W-1:0]] <= '0;
        end else if (i_cmd.rel_wr) begin
            r_mem[r_oldest[IDX_W-1:0]] <= {r_rdat.ver + 8'd1, r_rdat.pad,
                                           {mrsm_pkg::LEN_W{1'b0}}, r_rdat.ts,
                                           {mrsm_pkg::OFF_W{1'b0}}};
        end else if (i_cmd.app_wr) begin
            r_mem[r_next[IDX_W-1:0]] <= wdesc;
        end
        if (i_cmd.rel_rd || i_cmd.rd_rd || i_cmd.plan) begin
            r_rdat <= r_mem[rd_addr];
        end else if (i_cmd.rel_wr) begin
            r_rdat.ver <= r_rdat.ver + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_oldest <= '0;
            r_next   <= '0;
            r_reader <= '0;
            r_drop   <= '0;
            r_bhead  <= '0;
            r_btail  <= '0;
            r_round  <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.load) r_round <= '0;
            if (i_cmd.rel_wr) begin
                r_bhead  <= r_bhead + BPOS_W'(r_rdat.len);
                r_oldest <= r_oldest + 1'b1;
            end
            if (i_cmd.plan) begin
                r_app_pad <= !o_sts.fits;
                r_app_len <= o_sts.fits ? r_len : mrsm_pkg::LEN_W'(room);
                r_app_off <= mrsm_pkg::OFF_W'(tail_idx);
            end
            if (i_cmd.app_wr) begin
                r_btail <= r_btail + BPOS_W'(r_app_len);
                r_next  <= r_next + 1'b1;
                r_round <= r_round + 2'd1;
            end
            if (i_cmd.rewind) r_reader <= r_next;
            if (i_cmd.safe && gap > SAFE_SPAN) begin
                r_drop   <= r_drop + gap - SAFE_SPAN;
                r_reader <= r_next - SAFE_SPAN;
            end
            if (i_cmd.skip) begin
                r_reader <= r_reader + 1'b1;
                r_drop   <= r_drop + 1'b1;
            end
            if (i_cmd.adv_reader) r_reader <= r_reader + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_len  <= i_length;
            r_ts   <= i_timestamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_dropped <= r_drop;
            case (i_cmd.res_op)
                mrsm_pkg::OP_WRITE_OK: begin
                    o_status     <= mrsm_pkg::ST_OK;
                    o_offset     <= r_app_off;
                    o_msg_length <= r_len;
                    o_msg_time   <= r_ts;
                    o_version    <= r_rdat.ver;
                end
                mrsm_pkg::OP_DESC_OK, mrsm_pkg::OP_DESC_LIMIT: begin
                    o_status     <= (i_cmd.res_op == mrsm_pkg::OP_DESC_OK)
                                    ? mrsm_pkg::ST_OK : mrsm_pkg::ST_LIMIT;
                    o_offset     <= r_rdat.off;
                    o_msg_length <= r_rdat.len;
                    o_msg_time   <= r_rdat.ts;
                    o_version    <= r_rdat.ver;
                end
                default: begin
                    o_status     <= (i_cmd.res_op == mrsm_pkg::OP_BIG) ? mrsm_pkg::ST_BIG :
                                    (i_cmd.res_op == mrsm_pkg::OP_EMPTY) ? mrsm_pkg::ST_EMPTY
                                                                         : mrsm_pkg::ST_OK;
                    o_offset     <= '0;
                    o_msg_length <= '0;
                    o_msg_time   <= '0;
                    o_version    <= '0;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next - r_oldest) <= ENTRIES)
        else $error("descriptor ring overfilled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used <= BPOS_W'(BUF_BYTES))
        else $error("byte space overfilled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.app_wr |-> ((r_next - r_oldest) < ENTRIES))
        else $error("append into full ring");

endmodule
